// ===== rtl/spjq_pkg.sv =====
package spjq_pkg;

	localparam int CAPACITY      = 16;
	localparam int PRIO_W        = 8;
	localparam int PAYLOAD_W     = 32;
	localparam int COUNT_W       = $clog2(CAPACITY + 1);
	localparam int OUT_PRIO_W    = 8;
	localparam int OUT_PAYLOAD_W = 32;
	localparam int OUT_COUNT_W   = 5;

	typedef logic [PRIO_W-1:0]    prio_t;
	typedef logic [PAYLOAD_W-1:0] payload_t;
	typedef logic [COUNT_W-1:0]   count_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    insert;
		logic    pop;
		logic    capture;
		status_t code;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

// ===== rtl/spjq_req_if.sv =====
interface spjq_req_if;
	import spjq_pkg::*;

	logic     valid;
	logic     ready;
	logic     opcode;
	prio_t    job_priority;
	payload_t job_payload;

	modport source (output valid, output opcode, output job_priority, output job_payload,
		input ready);
	modport sink (input valid, input opcode, input job_priority, input job_payload,
		output ready);
endinterface

// ===== rtl/spjq_rsp_if.sv =====
interface spjq_rsp_if;
	import spjq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     popped_valid;
	logic [OUT_PRIO_W-1:0]    popped_priority;
	logic [OUT_PAYLOAD_W-1:0] popped_payload;
	logic [1:0]               status;
	logic [OUT_COUNT_W-1:0]   entry_count;

	modport source (output valid, output popped_valid, output popped_priority,
		output popped_payload, output status, output entry_count, input ready);
	modport sink (input valid, input popped_valid, input popped_priority,
		input popped_payload, input status, input entry_count, output ready);
endinterface

// ===== rtl/spjq_ctrl.sv =====
module spjq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_opcode,
	input  logic              out_ready,
	input  spjq_pkg::dp_stat_t stat,
	output logic              in_ready,
	output logic              out_valid,
	output spjq_pkg::dp_cmd_t  cmd
);
	import spjq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   in_fire;

	// take a word when no result is held or the held one leaves now
	assign in_ready = (state_q == ST_IDLE) || out_ready;
	assign in_fire  = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!in_fire && out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// outputs: decode the request against fill state
	always_comb begin
		out_valid   = (state_q == ST_RESULT);
		cmd.insert  = 1'b0;
		cmd.pop     = 1'b0;
		cmd.capture = in_fire;
		cmd.code    = STAT_OK;
		if (opcode_t'(in_opcode) == OP_INSERT) begin
			if (stat.full) begin
				cmd.code = STAT_FULL;
			end else begin
				cmd.insert = in_fire;
			end
		end else begin
			if (stat.empty) begin
				cmd.code = STAT_EMPTY;
			end else begin
				cmd.pop = in_fire;
			end
		end
	end

endmodule

// ===== rtl/spjq_dp.sv =====
module spjq_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spjq_pkg::dp_cmd_t                  cmd,
	input  spjq_pkg::prio_t                    job_priority,
	input  spjq_pkg::payload_t                 job_payload,
	output spjq_pkg::dp_stat_t                 stat,
	output logic                               popped_valid,
	output logic [spjq_pkg::OUT_PRIO_W-1:0]    popped_priority,
	output logic [spjq_pkg::OUT_PAYLOAD_W-1:0] popped_payload,
	output logic [1:0]                         status,
	output logic [spjq_pkg::OUT_COUNT_W-1:0]   entry_count
);
	import spjq_pkg::*;

	prio_t    prio_q [CAPACITY];
	payload_t load_q [CAPACITY];
	count_t   count_q;
	count_t   count_d;

	prio_t    prio_ins [CAPACITY];
	payload_t load_ins [CAPACITY];
	logic [CAPACITY-1:0] below;

	logic                     popped_valid_q;
	logic [OUT_PRIO_W-1:0]    popped_prio_q;
	logic [OUT_PAYLOAD_W-1:0] popped_load_q;
	status_t                  status_q;

	assign stat.full  = (count_q == COUNT_W'(CAPACITY));
	assign stat.empty = (count_q == '0);

	// mark slots at or past the insert point; descending order keeps this monotonic
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			below[i] = (COUNT_W'(i) >= count_q) || (prio_q[i] < job_priority);
		end
	end

	// each slot keeps, takes the new job, or takes its upper neighbor
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (i > 0 && below[(i > 0) ? i - 1 : 0]) begin
				prio_ins[i] = prio_q[(i > 0) ? i - 1 : 0];
				load_ins[i] = load_q[(i > 0) ? i - 1 : 0];
			end else if (below[i]) begin
				prio_ins[i] = job_priority;
				load_ins[i] = job_payload;
			end else begin
				prio_ins[i] = prio_q[i];
				load_ins[i] = load_q[i];
			end
		end
	end

	// shift the store on insert or pop
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			prio_q <= prio_ins;
			load_q <= load_ins;
		end else if (cmd.pop) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				prio_q[i] <= prio_q[i + 1];
				load_q[i] <= load_q[i + 1];
			end
		end
	end

	// track the fill count
	always_comb begin
		count_d = count_q;
		if (cmd.insert) begin
			count_d = count_q + COUNT_W'(1);
		end else if (cmd.pop) begin
			count_d = count_q - COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// hold the result word until the next request is taken
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			popped_valid_q <= cmd.pop;
			status_q       <= cmd.code;
			if (cmd.pop) begin
				popped_prio_q <= OUT_PRIO_W'(prio_q[0]);
				popped_load_q <= OUT_PAYLOAD_W'(load_q[0]);
			end else begin
				popped_prio_q <= '0;
				popped_load_q <= '0;
			end
		end
	end

	assign popped_valid    = popped_valid_q;
	assign popped_priority = popped_prio_q;
	assign popped_payload  = popped_load_q;
	assign status          = status_q;
	assign entry_count     = OUT_COUNT_W'(count_q);

endmodule

// ===== rtl/sorted_priority_job_queue.sv =====
// Bounded priority queue of jobs kept in descending priority order in a
// shift-register store of CAPACITY slots. Each request word either inserts a
// job (placed ahead of the first stored job of strictly lower priority, so equal
// priorities leave first in, first out) or pops the head job. Every request
// yields exactly one response word in the cycle after it is taken, carrying the
// popped job (zeros otherwise), a status code (ok, insert dropped because full,
// pop on empty) and the fill count after the operation. One request is taken per
// cycle if output flows: all slots compare against the new priority in parallel
// and shift in the accept cycle, and the response register frees in the same
// cycle its word is taken downstream. The store needs no clearing after reset.
module sorted_priority_job_queue (
	input logic       clk,
	input logic       arst_n,
	spjq_req_if.sink  req,
	spjq_rsp_if.source rsp
);
	import spjq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	spjq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.out_ready (rsp.ready),
		.stat      (stat),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	spjq_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.job_priority    (req.job_priority),
		.job_payload     (req.job_payload),
		.stat            (stat),
		.popped_valid    (rsp.popped_valid),
		.popped_priority (rsp.popped_priority),
		.popped_payload  (rsp.popped_payload),
		.status          (rsp.status),
		.entry_count     (rsp.entry_count)
	);

endmodule

// ===== sim/sorted_priority_job_queue_tb.sv =====
module sorted_priority_job_queue_tb;
	import spjq_pkg::*;

	localparam int GAP_MAX = 14;
	localparam int RANDOM_JOBS = 450;

	// one response word as the queue reports it
	typedef struct {
		logic                     popped_valid;
		logic [OUT_PRIO_W-1:0]    popped_priority;
		logic [OUT_PAYLOAD_W-1:0] popped_payload;
		status_t                  status;
		logic [OUT_COUNT_W-1:0]   entry_count;
	} job_word_t;

	// one row of the directed script
	typedef struct {
		opcode_t   op;
		prio_t     prio;
		payload_t  payload;
		int        reps;
		bit        typed;
		job_word_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;

	spjq_req_if req_ch ();
	spjq_rsp_if rsp_ch ();

	sorted_priority_job_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	// shadow copy of the sorted store
	prio_t    shadow_prio [CAPACITY];
	payload_t shadow_load [CAPACITY];
	int       shadow_len;

	job_word_t   awaited_words[$];
	script_row_t script[$];

	int  n_errors;
	int  n_sent;
	int  n_checked;
	int  n_popped;
	int  n_dropped;
	int  n_empty;
	bit  src_no_idle;
	bit  snk_no_idle;

	function automatic script_row_t job_row(opcode_t op, prio_t prio, payload_t payload,
		int reps);
		script_row_t r;
		r.op = op;
		r.prio = prio;
		r.payload = payload;
		r.reps = reps;
		r.typed = 1'b0;
		r.want.popped_valid = 1'b0;
		r.want.popped_priority = '0;
		r.want.popped_payload = '0;
		r.want.status = STAT_OK;
		r.want.entry_count = '0;
		return r;
	endfunction

	function automatic script_row_t checked_row(opcode_t op, prio_t prio, payload_t payload,
		logic pv, logic [OUT_PRIO_W-1:0] pp, logic [OUT_PAYLOAD_W-1:0] pl, status_t st,
		int cnt);
		script_row_t r;
		r = job_row(op, prio, payload, 1);
		r.typed = 1'b1;
		r.want.popped_valid = pv;
		r.want.popped_priority = pp;
		r.want.popped_payload = pl;
		r.want.status = st;
		r.want.entry_count = cnt[OUT_COUNT_W-1:0];
		return r;
	endfunction

	// apply one request to the shadow store and return the word it yields
	function automatic job_word_t queue_apply(opcode_t op, prio_t prio, payload_t payload);
		job_word_t w;
		int pos;
		bit found;
		w.popped_valid = 1'b0;
		w.popped_priority = '0;
		w.popped_payload = '0;
		w.status = STAT_OK;
		if (op == OP_INSERT) begin
			if (shadow_len >= CAPACITY) begin
				w.status = STAT_FULL;
			end else begin
				// place ahead of the first strictly lower priority
				pos = shadow_len;
				found = 1'b0;
				for (int i = 0; i < shadow_len; i++) begin
					if (!found && shadow_prio[i] < prio) begin
						pos = i;
						found = 1'b1;
					end
				end
				for (int i = shadow_len; i > pos; i--) begin
					shadow_prio[i] = shadow_prio[i-1];
					shadow_load[i] = shadow_load[i-1];
				end
				shadow_prio[pos] = prio;
				shadow_load[pos] = payload;
				shadow_len++;
			end
		end else begin
			if (shadow_len == 0) begin
				w.status = STAT_EMPTY;
			end else begin
				w.popped_valid = 1'b1;
				w.popped_priority = shadow_prio[0];
				w.popped_payload = shadow_load[0];
				for (int i = 1; i < shadow_len; i++) begin
					shadow_prio[i-1] = shadow_prio[i];
					shadow_load[i-1] = shadow_load[i];
				end
				shadow_len--;
			end
		end
		w.entry_count = shadow_len[OUT_COUNT_W-1:0];
		return w;
	endfunction

	// present one request word, wait for it to be taken, record its expectation
	task automatic send_job(opcode_t op, prio_t prio, payload_t payload, bit typed,
		job_word_t want);
		int gap;
		job_word_t w;
		gap = src_no_idle ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.job_priority <= prio;
		req_ch.job_payload <= payload;
		do @(negedge clk); while (!req_ch.ready);
		@(posedge clk);
		w = queue_apply(op, prio, payload);
		awaited_words.push_back(typed ? want : w);
		n_sent++;
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
			n_errors++;
		end
	endtask

	// compare each response word taken downstream with the oldest expectation
	always @(negedge clk) begin
		job_word_t w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_words.size() == 0) begin
				$display("%0t: response word with no request outstanding", $time);
				n_errors++;
			end else begin
				w = awaited_words.pop_front();
				check_field("popped_valid", w.popped_valid, rsp_ch.popped_valid);
				check_field("popped_priority", w.popped_priority, rsp_ch.popped_priority);
				check_field("popped_payload", w.popped_payload, rsp_ch.popped_payload);
				check_field("status", w.status, rsp_ch.status);
				check_field("entry_count", w.entry_count, rsp_ch.entry_count);
				n_checked++;
				if (w.popped_valid)
					n_popped++;
				if (w.status == STAT_FULL)
					n_dropped++;
				if (w.status == STAT_EMPTY)
					n_empty++;
			end
		end
	end

	// downstream side: stall a random number of cycles before each word
	initial begin
		int stall;
		int taken;
		rsp_ch.ready <= 1'b0;
		snk_no_idle = 1'b0;
		taken = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (taken % 32 == 0)
				snk_no_idle = ($urandom_range(0, 3) == 0);
			stall = snk_no_idle ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(negedge clk); while (!rsp_ch.valid);
			@(posedge clk);
			taken++;
		end
	end

	// end the run if the queue stops answering
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		job_word_t none;
		script_row_t blank_row;
		int phase_len;
		int insert_pct;
		int prio_mode;
		opcode_t op;
		prio_t prio;

		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_popped = 0;
		n_dropped = 0;
		n_empty = 0;
		src_no_idle = 1'b0;
		shadow_len = 0;
		blank_row = job_row(OP_INSERT, '0, '0, 1);
		none = blank_row.want;

		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_INSERT;
		req_ch.job_priority <= '0;
		req_ch.job_payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script: empty, extremes, ties, fill to capacity, drain
		script.push_back(checked_row(OP_POP, 8'h00, 32'h0, 1'b0, 8'h00, 32'h0, STAT_EMPTY, 0));
		script.push_back(checked_row(OP_INSERT, 8'h00, 32'h0, 1'b0, 8'h00, 32'h0, STAT_OK, 1));
		script.push_back(checked_row(OP_POP, 8'hff, 32'hffff_ffff, 1'b1, 8'h00, 32'h0,
			STAT_OK, 0));
		script.push_back(checked_row(OP_INSERT, 8'hff, 32'hffff_ffff, 1'b0, 8'h00, 32'h0,
			STAT_OK, 1));
		script.push_back(job_row(OP_INSERT, 8'h00, 32'h1234_5678, 1));
		script.push_back(job_row(OP_INSERT, 8'hff, 32'ha5a5_a5a5, 1));
		script.push_back(job_row(OP_INSERT, 8'h80, 32'h5a5a_5a5a, 1));
		script.push_back(job_row(OP_INSERT, 8'h80, 32'h0000_ffff, 1));
		script.push_back(job_row(OP_POP, 8'h3c, 32'hdead_beef, 2));
		script.push_back(job_row(OP_INSERT, 8'h01, 32'hffff_0000, 1));
		script.push_back(job_row(OP_INSERT, 8'hc8, 32'hc3c3_c300, 12));
		script.push_back(checked_row(OP_INSERT, 8'hff, 32'hffff_ffff, 1'b0, 8'h00, 32'h0,
			STAT_FULL, CAPACITY));
		script.push_back(checked_row(OP_INSERT, 8'h00, 32'h0, 1'b0, 8'h00, 32'h0,
			STAT_FULL, CAPACITY));
		script.push_back(job_row(OP_POP, 8'h00, 32'h0, 1));
		script.push_back(job_row(OP_INSERT, 8'hc8, 32'h7777_0000, 1));
		script.push_back(job_row(OP_POP, 8'h55, 32'h0, CAPACITY));
		script.push_back(checked_row(OP_POP, 8'hff, 32'hffff_ffff, 1'b0, 8'h00, 32'h0,
			STAT_EMPTY, 0));

		foreach (script[r]) begin
			for (int k = 0; k < script[r].reps; k++)
				send_job(script[r].op, script[r].prio, script[r].payload + k, script[r].typed,
					script[r].want);
		end

		// random phases: fill-heavy, drain-heavy or balanced, with varied priority spread
		while (n_sent < script.size() + RANDOM_JOBS) begin
			phase_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: begin
					insert_pct = 85;
				end
				1: begin
					insert_pct = 15;
				end
				default: begin
					insert_pct = 50;
				end
			endcase
			prio_mode = $urandom_range(0, 2);
			src_no_idle = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
				case (prio_mode)
					0: begin
						prio = PRIO_W'($urandom_range(0, 255));
					end
					1: begin
						case ($urandom_range(0, 3))
							0: prio = 8'h00;
							1: prio = 8'h01;
							2: prio = 8'h80;
							default: prio = 8'hff;
						endcase
					end
					default: begin
						prio = PRIO_W'($urandom_range(100, 103));
					end
				endcase
				send_job(op, prio, $urandom, 1'b0, none);
			end
		end

		// drain: let every outstanding word arrive, then a few quiet cycles
		req_ch.valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d requests sent, %0d response words checked", n_sent, n_checked);
		$display("%0d jobs popped, %0d inserts dropped when full, %0d pops on empty",
			n_popped, n_dropped, n_empty);
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/spjq_pkg.sv
rtl/spjq_req_if.sv
rtl/spjq_rsp_if.sv
rtl/spjq_ctrl.sv
rtl/spjq_dp.sv
rtl/sorted_priority_job_queue.sv
sim/sorted_priority_job_queue_tb.sv
